// ===== src/elos_pkg.sv =====
// ----------------------------------------------------------------------------
// Ellipsoid line-of-sight package
// Shared widths, reset values and register indexes.
// ----------------------------------------------------------------------------
package elos_pkg;

  localparam int AXIS_BITS      = 26;
  localparam int FRAC_BITS      = 32;
  localparam int DIG_BITS       = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [AXIS_BITS-1:0] EQ_AXIS_RESET  = 26'd6378137;
  localparam logic [AXIS_BITS-1:0] POL_AXIS_RESET = 26'd6356752;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EQ_AXIS  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POL_AXIS = 1'b1;

endpackage

// ===== src/elos_mul.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned multiplier
// Digit partial products, row sums, then one row accumulated per stage.
// ----------------------------------------------------------------------------
module elos_mul #(
  parameter int AW  = 64,
  parameter int BW  = 64,
  parameter int LAT = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW+BW-1:0] p
);

  localparam int DIG = elos_pkg::DIG_BITS;
  localparam int KA  = (AW + DIG - 1) / DIG;
  localparam int KB  = (BW + DIG - 1) / DIG;
  localparam int PW  = AW + BW;
  localparam int RW  = (KA + 1) * DIG;
  localparam int ACW = (KA + KB) * DIG;
  localparam int PAD = LAT - 2 - KB;

  logic [KA*DIG-1:0] ax;
  logic [KB*DIG-1:0] bx;
  logic [2*DIG-1:0]  pp_r   [0:KB-1][0:KA-1];
  logic [RW-1:0]     row    [0:KB-1];
  logic [RW-1:0]     row_r  [0:KB-1];
  logic [RW-1:0]     rowp_r [0:KB-1][0:KB-1];
  logic [ACW-1:0]    acc_r  [0:KB-1];

  assign ax = (KA*DIG)'(a);
  assign bx = (KB*DIG)'(b);

  always_comb begin
    logic [RW-1:0] ev;
    logic [RW-1:0] od;
    for (int j = 0; j < KB; j++) begin
      ev = '0;
      od = '0;
      for (int i = 0; i < KA; i++) begin
        if ((i & 1) == 0) begin
          ev = ev | (RW'(pp_r[j][i]) << (DIG * i));
        end else begin
          od = od | (RW'(pp_r[j][i]) << (DIG * i));
        end
      end
      row[j] = ev + od;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < KB; j++) begin
        for (int i = 0; i < KA; i++) begin
          pp_r[j][i] <= ax[DIG*i +: DIG] * bx[DIG*j +: DIG];
        end
        row_r[j]     <= row[j];
        rowp_r[0][j] <= row_r[j];
      end
      acc_r[0] <= ACW'(row_r[0]);
      for (int k = 1; k < KB; k++) begin
        for (int j = 0; j < KB; j++) begin
          rowp_r[k][j] <= rowp_r[k-1][j];
        end
        acc_r[k] <= acc_r[k-1] + (ACW'(rowp_r[k-1][k]) << (DIG * k));
      end
    end
  end

  generate
    if (PAD > 0) begin : g_pad
      logic [PW-1:0] pd_r [0:PAD-1];
      always_ff @(posedge clk) begin
        if (en) begin
          pd_r[0] <= acc_r[KB-1][PW-1:0];
          for (int k = 1; k < PAD; k++) begin
            pd_r[k] <= pd_r[k-1];
          end
        end
      end
      assign p = pd_r[PAD-1];
    end else begin : g_nopad
      assign p = acc_r[KB-1][PW-1:0];
    end
  endgenerate

endmodule

// ===== src/ellipsoid_line_of_sight_unit.sv =====
// ----------------------------------------------------------------------------
// Ellipsoid line-of-sight unit
// Exact fixed-point test of whether the segment between two points clears
// an ellipsoid, one position pair per transaction.
// ----------------------------------------------------------------------------
// The unit takes one position pair per clock cycle while in_tready is high
// and returns one in_view flag per pair, in order. Most of the pipeline is
// the bit-per-stage divider that scales the coordinates by the axes.
// An output register with a skid stage lets the input side keep accepting
// while a result waits. Axis registers may only be written while idle.
module ellipsoid_line_of_sight_unit #(
  parameter int COORD_BITS = 27
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // receiver_x, receiver_y, receiver_z, transmitter_x, transmitter_y,
  // transmitter_z, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // in_view, zero fill
  output logic [elos_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [elos_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [elos_pkg::AXIS_BITS-1:0] cfg_wdata
);

  localparam int W     = COORD_BITS;
  localparam int AXB   = elos_pkg::AXIS_BITS;
  localparam int FB    = elos_pkg::FRAC_BITS;
  localparam int DIG   = elos_pkg::DIG_BITS;
  localparam int QW    = W + FB;
  localparam int SW    = QW + 1;
  localparam int DW    = QW + 2;
  localparam int DMW   = QW + 1;
  localparam int PPW   = 2 * QW + 2;
  localparam int DDW   = 2 * DMW + 2;
  localparam int BP    = QW + DMW;
  localparam int BSW   = BP + 3;
  localparam int BMW   = BP + 2;
  localparam int P2W   = DDW + PPW;
  localparam int LAT1  = 2 + (DMW + DIG - 1) / DIG;
  localparam int LAT2  = 2 + (DDW + DIG - 1) / DIG;
  localparam int DEPTH = QW + LAT1 + LAT2 + 8;

  logic [AXB-1:0] eq_axis_r;
  logic [AXB-1:0] pol_axis_r;
  logic           en;
  logic [DEPTH-1:0] vld_r;

  logic [QW-1:0]  dq_r   [0:QW][0:5];
  logic [AXB-1:0] drem_r [0:QW][0:5];
  logic [5:0]     dneg_r [0:QW];
  logic [QW-1:0]  dq_nxt   [0:QW-1][0:5];
  logic [AXB-1:0] drem_nxt [0:QW-1][0:5];
  logic [W-1:0]   in_mag [0:5];
  logic [5:0]     in_neg;

  logic signed [SW-1:0] sa_r [0:5];
  logic [QW-1:0]        qa_r [0:5];
  logic [5:0]           na_r;
  logic signed [DW-1:0] db_r [0:2];
  logic [QW-1:0]        qb_r [0:5];
  logic [5:0]           nb_r;
  logic [DMW-1:0]       dmc_r [0:2];
  logic [QW-1:0]        qc_r [0:5];
  logic [5:0]           sgc_r;

  logic [2*QW-1:0]  sqr [0:2];
  logic [2*QW-1:0]  sqt [0:2];
  logic [2*DMW-1:0] sqd [0:2];
  logic [BP-1:0]    pbr [0:2];
  logic [BP-1:0]    pbt [0:2];
  logic [5:0]       sg1_r [0:LAT1-1];

  logic [PPW-1:0]        ppr_r, ppt_r;
  logic [DDW-1:0]        dd1_r;
  logic signed [BSW-1:0] bts_r [0:5];
  logic [PPW-1:0]        ppr2_r, ppt2_r;
  logic [DDW-1:0]        dd2_r;
  logic signed [BSW-1:0] bsr_r, bst_r;
  logic [PPW-1:0]        cmr_r, cmt_r;
  logic [BMW-1:0]        bmr_r, bmt_r;
  logic [DDW-1:0]        dde_r;
  logic [3:0]            fle_r;
  logic [3:0]            fl2_r [0:LAT2-1];
  logic [P2W-1:0]        pcr, pct, pbr2, pbt2;
  logic                  view_r;

  logic out_vld_r, out_view_r, skid_vld_r, skid_view_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // Configuration registers; a zero axis counts as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_axis_r  <= elos_pkg::EQ_AXIS_RESET;
      pol_axis_r <= elos_pkg::POL_AXIS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        elos_pkg::CFG_EQ_AXIS:
          eq_axis_r <= (cfg_wdata == '0) ? AXB'(1) : cfg_wdata;
        elos_pkg::CFG_POL_AXIS:
          pol_axis_r <= (cfg_wdata == '0) ? AXB'(1) : cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_comb begin
    logic [W-1:0] raw;
    for (int f = 0; f < 6; f++) begin
      raw       = in_tdata[W*f +: W];
      in_neg[f] = raw[W-1];
      in_mag[f] = raw[W-1] ? (~raw + W'(1)) : raw;
    end
  end

  always_comb begin
    logic [AXB:0]   sh;
    logic [AXB-1:0] ax;
    logic           ge;
    for (int k = 0; k < QW; k++) begin
      for (int f = 0; f < 6; f++) begin
        ax = (f == 2 || f == 5) ? pol_axis_r : eq_axis_r;
        sh = {drem_r[k][f], dq_r[k][f][QW-1]};
        ge = sh >= {1'b0, ax};
        drem_nxt[k][f] = ge ? AXB'(sh - {1'b0, ax}) : sh[AXB-1:0];
        dq_nxt[k][f]   = {dq_r[k][f][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < 6; f++) begin
        dq_r[0][f]   <= {in_mag[f], {FB{1'b0}}};
        drem_r[0][f] <= '0;
      end
      dneg_r[0] <= in_neg;
      for (int k = 0; k < QW; k++) begin
        for (int f = 0; f < 6; f++) begin
          dq_r[k+1][f]   <= dq_nxt[k][f];
          drem_r[k+1][f] <= drem_nxt[k][f];
        end
        dneg_r[k+1] <= dneg_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < 6; f++) begin
        sa_r[f] <= dneg_r[QW][f] ? -$signed({1'b0, dq_r[QW][f]})
                                 : $signed({1'b0, dq_r[QW][f]});
        qa_r[f] <= dq_r[QW][f];
        qb_r[f] <= qa_r[f];
        qc_r[f] <= qb_r[f];
      end
      na_r <= dneg_r[QW];
      nb_r <= na_r;
      for (int i = 0; i < 3; i++) begin
        db_r[i] <= DW'(sa_r[i+3]) - DW'(sa_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] dabs;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dabs       = db_r[i][DW-1] ? -db_r[i] : db_r[i];
        dmc_r[i]   <= dabs[DMW-1:0];
        sgc_r[i]   <= nb_r[i] ^ db_r[i][DW-1];
        sgc_r[i+3] <= nb_r[i+3] ^ ~db_r[i][DW-1];
      end
    end
  end

  generate
    for (genvar i = 0; i < 3; i++) begin : g_l1
      elos_mul #(.AW(QW), .BW(QW), .LAT(LAT1)) u_sqr (
        .clk(clk), .en(en), .a(qc_r[i]), .b(qc_r[i]), .p(sqr[i]));
      elos_mul #(.AW(QW), .BW(QW), .LAT(LAT1)) u_sqt (
        .clk(clk), .en(en), .a(qc_r[i+3]), .b(qc_r[i+3]), .p(sqt[i]));
      elos_mul #(.AW(DMW), .BW(DMW), .LAT(LAT1)) u_sqd (
        .clk(clk), .en(en), .a(dmc_r[i]), .b(dmc_r[i]), .p(sqd[i]));
      elos_mul #(.AW(QW), .BW(DMW), .LAT(LAT1)) u_pbr (
        .clk(clk), .en(en), .a(qc_r[i]), .b(dmc_r[i]), .p(pbr[i]));
      elos_mul #(.AW(QW), .BW(DMW), .LAT(LAT1)) u_pbt (
        .clk(clk), .en(en), .a(qc_r[i+3]), .b(dmc_r[i]), .p(pbt[i]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sg1_r[0] <= sgc_r;
      for (int k = 1; k < LAT1; k++) begin
        sg1_r[k] <= sg1_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ppr_r <= PPW'(sqr[0]) + PPW'(sqr[1]) + PPW'(sqr[2]);
      ppt_r <= PPW'(sqt[0]) + PPW'(sqt[1]) + PPW'(sqt[2]);
      dd1_r <= DDW'(sqd[0]) + DDW'(sqd[1]) + DDW'(sqd[2]);
      for (int i = 0; i < 3; i++) begin
        bts_r[i]   <= sg1_r[LAT1-1][i] ? -$signed(BSW'(pbr[i])) : $signed(BSW'(pbr[i]));
        bts_r[i+3] <= sg1_r[LAT1-1][i+3] ? -$signed(BSW'(pbt[i]))
                                         : $signed(BSW'(pbt[i]));
      end
      ppr2_r <= ppr_r;
      ppt2_r <= ppt_r;
      dd2_r  <= dd1_r;
      bsr_r  <= bts_r[0] + bts_r[1] + bts_r[2];
      bst_r  <= bts_r[3] + bts_r[4] + bts_r[5];
    end
  end

  always_ff @(posedge clk) begin
    logic [PPW-1:0] one_sq;
    logic [BSW-1:0] babs_r;
    logic [BSW-1:0] babs_t;
    if (en) begin
      one_sq   = PPW'(1) << (2 * FB);
      babs_r   = bsr_r[BSW-1] ? -bsr_r : bsr_r;
      babs_t   = bst_r[BSW-1] ? -bst_r : bst_r;
      cmr_r    <= ppr2_r - one_sq;
      cmt_r    <= ppt2_r - one_sq;
      bmr_r    <= babs_r[BMW-1:0];
      bmt_r    <= babs_t[BMW-1:0];
      dde_r    <= dd2_r;
      fle_r[0] <= ppr2_r > one_sq;
      fle_r[1] <= !bsr_r[BSW-1] && (bsr_r != '0);
      fle_r[2] <= ppt2_r > one_sq;
      fle_r[3] <= !bst_r[BSW-1] && (bst_r != '0);
    end
  end

  elos_mul #(.AW(DDW), .BW(PPW), .LAT(LAT2)) u_pcr (
    .clk(clk), .en(en), .a(dde_r), .b(cmr_r), .p(pcr));
  elos_mul #(.AW(DDW), .BW(PPW), .LAT(LAT2)) u_pct (
    .clk(clk), .en(en), .a(dde_r), .b(cmt_r), .p(pct));
  elos_mul #(.AW(BMW), .BW(BMW), .LAT(LAT2)) u_pbr2 (
    .clk(clk), .en(en), .a(bmr_r), .b(bmr_r), .p(pbr2));
  elos_mul #(.AW(BMW), .BW(BMW), .LAT(LAT2)) u_pbt2 (
    .clk(clk), .en(en), .a(bmt_r), .b(bmt_r), .p(pbt2));

  always_ff @(posedge clk) begin
    if (en) begin
      fl2_r[0] <= fle_r;
      for (int k = 1; k < LAT2; k++) begin
        fl2_r[k] <= fl2_r[k-1];
      end
      view_r <= (fl2_r[LAT2-1][0] && (fl2_r[LAT2-1][1] || (pcr > pbr2))) ||
                (fl2_r[LAT2-1][2] && (fl2_r[LAT2-1][3] || (pct > pbt2)));
    end
  end

  // Output register with a one-entry skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        out_view_r <= skid_view_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_r  <= vld_r[DEPTH-1];
      out_view_r <= view_r;
    end else if (vld_r[DEPTH-1]) begin
      skid_vld_r  <= 1'b1;
      skid_view_r <= view_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(elos_pkg::OUT_TDATA_BITS-1){1'b0}}, out_view_r};

endmodule

// ===== test/ellipsoid_line_of_sight_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipsoid line-of-sight unit testbench
// Drives position pairs through the stream interface under random idling and
// back-pressure, predicts each in_view flag with exact wide arithmetic and
// checks the results in order across several axis settings.
// ----------------------------------------------------------------------------
module ellipsoid_line_of_sight_unit_tb;

  localparam int CB = 27;
  localparam int IN_W = ((6*CB+7)/8)*8;
  localparam int LATENCY = 77;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [elos_pkg::AXIS_BITS-1:0] AXIS_MAX = 26'h3ffffff;

  typedef logic signed [319:0] wide_t;
  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t rx, ry, rz, tx, ty, tz;
    int     want;
  } pair_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [elos_pkg::OUT_TDATA_BITS-1:0] out_tdata;
  logic cfg_we;
  logic [elos_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [elos_pkg::AXIS_BITS-1:0] cfg_wdata;

  logic [elos_pkg::AXIS_BITS-1:0] eq_axis;
  logic [elos_pkg::AXIS_BITS-1:0] pol_axis;
  logic view_due[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  bit sender_busy_stretch;

  ellipsoid_line_of_sight_unit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic wide_t scaled(coord_t c, logic [elos_pkg::AXIS_BITS-1:0] ax);
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] div;
    div = (ax == '0) ? 64'd1 : {38'd0, ax};
    mag = c[CB-1] ? ((64'd1 << CB) - {37'd0, c}) : {37'd0, c};
    quo = (mag << 32) / div;
    return c[CB-1] ? -wide_t'(quo) : wide_t'(quo);
  endfunction

  function automatic wide_t dot3(wide_t a[3], wide_t b[3]);
    return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
  endfunction

  function automatic bit ray_clear(wide_t p[3], wide_t d[3]);
    wide_t c, b, dd, disc;
    c = dot3(p, p) - (wide_t'(1) << 64);
    if (c <= 0) return 1'b0;
    b = dot3(p, d);
    if (b > 0) return 1'b1;
    dd = dot3(d, d);
    disc = dd*c - b*b;
    return disc > 0;
  endfunction

  function automatic bit line_of_sight(pair_row_t r);
    wide_t pr[3], pt[3], drt[3], dtr[3];
    pr[0] = scaled(r.rx, eq_axis);
    pr[1] = scaled(r.ry, eq_axis);
    pr[2] = scaled(r.rz, pol_axis);
    pt[0] = scaled(r.tx, eq_axis);
    pt[1] = scaled(r.ty, eq_axis);
    pt[2] = scaled(r.tz, pol_axis);
    for (int i = 0; i < 3; i++) begin
      drt[i] = pt[i] - pr[i];
      dtr[i] = pr[i] - pt[i];
    end
    return ray_clear(pr, drt) || ray_clear(pt, dtr);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_axis(logic [elos_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [elos_pkg::AXIS_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == elos_pkg::CFG_EQ_AXIS) eq_axis = val;
    else pol_axis = val;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (view_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic send_pair(pair_row_t r);
    while (!sender_busy_stretch && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, r.tz, r.ty, r.tx, r.rz, r.ry, r.rx};
    do @(posedge clk); while (!in_tready);
    if (r.want >= 0 && r.want != line_of_sight(r))
      report_mismatch("directed row disagrees with predictor");
    view_due.push_back(r.want >= 0 ? r.want[0] : line_of_sight(r));
  endtask

  function automatic coord_t rand_coord(int mode);
    int span;
    int v;
    if (mode == 0) return coord_t'($urandom);
    span = (mode == 1) ? 2 * int'(eq_axis) + 1 : 8000000;
    if (span > 67108863) span = 67108863;
    v = $urandom_range(0, span);
    return coord_t'($urandom_range(0, 1) ? -v : v);
  endfunction

  function automatic pair_row_t rand_pair();
    pair_row_t r;
    int mode;
    mode = $urandom_range(0, 2);
    r.rx = rand_coord(mode); r.ry = rand_coord(mode); r.rz = rand_coord(mode);
    mode = $urandom_range(0, 2);
    r.tx = rand_coord(mode); r.ty = rand_coord(mode); r.tz = rand_coord(mode);
    if ($urandom_range(0, 19) == 0) begin
      r.tx = r.rx; r.ty = r.ry; r.tz = r.rz;
    end
    r.want = -1;
    return r;
  endfunction

  pair_row_t directed[$];

  initial begin
    localparam coord_t CMAX = 27'sh3ffffff;
    localparam coord_t CMIN = -27'sh4000000;
    directed = '{
      '{0, 0, 0, 0, 0, 0, 0},
      '{20000000, 0, 0, 20000000, 0, 0, 0},
      '{0, 0, 0, 20000000, 0, 0, 0},
      '{20000000, 0, 0, -20000000, 0, 0, 0},
      '{0, 0, 20000000, 0, 0, -20000000, 0},
      '{20000000, 0, 0, 20000000, 1000, 0, 1},
      '{20000000, 20000000, 0, 20000000, -20000000, 0, -1},
      '{6378137, 0, 0, 6378137, 0, 0, 0},
      '{6378137, 0, 0, 6378137, 100, 0, -1},
      '{0, 0, 6356752, 0, 0, 9000000, -1},
      '{3000000, 2000000, 1000000, 30000000, 0, 0, 0},
      '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0},
      '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0},
      '{CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, -1},
      '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, -1},
      '{CMAX, 0, 0, 0, CMAX, 0, -1},
      '{-1, -1, -1, 1, 1, 1, -1},
      '{CMIN, 0, 0, CMIN, 1, 0, 1}
    };
  end

  initial begin
    int phase_items;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = elos_pkg::CFG_EQ_AXIS;
    cfg_wdata = '0;
    eq_axis = elos_pkg::EQ_AXIS_RESET;
    pol_axis = elos_pkg::POL_AXIS_RESET;
    sender_busy_stretch = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_pair(directed[i]);
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        1: begin
          write_axis(elos_pkg::CFG_EQ_AXIS, AXIS_MAX);
          write_axis(elos_pkg::CFG_POL_AXIS, AXIS_MAX);
        end
        2: begin
          write_axis(elos_pkg::CFG_EQ_AXIS, 26'd1);
          write_axis(elos_pkg::CFG_POL_AXIS, 26'd1);
        end
        3: begin
          write_axis(elos_pkg::CFG_EQ_AXIS, '0);
          write_axis(elos_pkg::CFG_POL_AXIS, '0);
        end
        4: begin
          write_axis(elos_pkg::CFG_EQ_AXIS, elos_pkg::AXIS_BITS'($urandom));
          write_axis(elos_pkg::CFG_POL_AXIS, elos_pkg::AXIS_BITS'($urandom));
        end
        5: begin
          write_axis(elos_pkg::CFG_EQ_AXIS, elos_pkg::EQ_AXIS_RESET);
          write_axis(elos_pkg::CFG_POL_AXIS, elos_pkg::POL_AXIS_RESET);
        end
        default: ;
      endcase
      cfg_we <= 1'b0;
      phase_items = (phase == 0) ? 400 : 190;
      for (int n = 0; n < phase_items; n++) begin
        sender_busy_stretch = (phase == 0 && n >= 150 && n < 350);
        if (phase == 0 && n == 100) drain();
        send_pair(rand_pair());
      end
    end
    drain();
    if (errors == 0) $display("ellipsoid_line_of_sight_unit_tb: done, clean");
    else $display("ellipsoid_line_of_sight_unit_tb: done, errors");
    $finish;
  end

  initial begin
    int hold;
    bit held;
    out_tready = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        out_tready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      if (cycles > 4000 && cycles < 7000) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ellipsoid_line_of_sight_unit_tb: done, errors");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (view_due.size() == 0) report_mismatch("result with nothing expected");
      else if (out_tdata !== {{(elos_pkg::OUT_TDATA_BITS-1){1'b0}}, view_due[0]}) begin
        report_mismatch($sformatf("in_view got %h want %b", out_tdata, view_due[0]));
        void'(view_due.pop_front());
      end
      else void'(view_due.pop_front());
    end
  end

endmodule

// ===== sim.f =====
src/elos_pkg.sv
src/elos_mul.sv
src/ellipsoid_line_of_sight_unit.sv
test/ellipsoid_line_of_sight_unit_tb.sv
